// File: sv/utf8_to_utf16_transcoder_core_assert.svh
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder assertion macros
// Property shorthands sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_TRANSCODER_CORE_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_CORE_ASSERT_SVH

// Same-cycle implication
`define U8U16_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8u16 same-cycle check failed");

// Next-cycle implication
`define U8U16_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8u16 next-cycle check failed");

`endif

// File: sv/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

    localparam int PointWidth = 21;
    localparam int UnitWidth  = 16;
    localparam int QDepth     = 4;
    localparam int QPtrWidth  = $clog2(QDepth);
    localparam int QCntWidth  = $clog2(QDepth + 1);

    localparam logic [7:0]            Lead4     = 8'hF0;
    localparam logic [7:0]            Lead3     = 8'hE0;
    localparam logic [7:0]            Lead2     = 8'hC0;
    localparam logic [7:0]            ContMask  = 8'h3F;
    localparam logic [PointWidth-1:0] SuppBase  = 21'h010000;
    localparam logic [UnitWidth-1:0]  HighBase  = 16'hD800;
    localparam logic [UnitWidth-1:0]  LowBase   = 16'hDC00;

    // One decoded code point handed from front to back
    typedef struct packed {
        logic [PointWidth-1:0] point;
        logic                  last;
    } point_entry_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    // Back-end status for checking
    typedef struct packed {
        logic out_valid;
        logic low_pending;
    } back_status_t;

endpackage

`default_nettype wire

// File: sv/utf8_to_utf16_transcoder_core.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_core
// Lenient UTF-8 to UTF-16 transcoder: byte decoder front, point queue,
// code unit back end with surrogate skid slot.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake     | payload
//   ---------+-----------+---------------+-------------------------------------
//   bytes    | in        | push / full   | byte_in[7:0], string_end
//   units    | out       | empty / pop   | code_unit[15:0], run_end, final_unit
//
// One byte accepted per cycle while the four-entry point queue has room.
// A code point below 0x10000 leaves as one unit, one at or above it as two units,
// high surrogate first; the output side drains one unit per cycle while pop is held.
// The last byte of a code point writes it into the point queue; it then
// moves into the output register. Reset is asynchronous, active low; no clearing pass.
// A stalled output fills the queue, then full rises.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_to_utf16_transcoder_core_assert.svh"

module utf8_to_utf16_transcoder_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  byte_in,
    input  wire logic        string_end,
    input  wire logic        pop,
    output logic             empty,
    output logic [15:0]      code_unit,
    output logic             run_end,
    output logic             final_unit
);

    logic                       byte_accept;
    logic                       q_push;
    logic                       q_pop;
    u8u16_pkg::point_entry_t    q_wr_entry;
    u8u16_pkg::point_entry_t    q_rd_entry;
    u8u16_pkg::queue_status_t   q_status;
    u8u16_pkg::back_status_t    b_status;

    assign full        = q_status.full;
    assign byte_accept = push && !q_status.full;

    u8u16_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (byte_accept),
        .byte_in     (byte_in),
        .string_end  (string_end),
        .q_push      (q_push),
        .q_entry     (q_wr_entry)
    );

    u8u16_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_entry (q_wr_entry),
        .rd_en    (q_pop),
        .rd_entry (q_rd_entry),
        .status   (q_status)
    );

    u8u16_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_entry    (q_rd_entry),
        .q_status   (q_status),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .code_unit  (code_unit),
        .run_end    (run_end),
        .final_unit (final_unit),
        .status     (b_status)
    );

    // Checks
    `U8U16_ASSERT_SAME(a_low_behind_output, b_status.low_pending, !empty)
    `U8U16_ASSERT_SAME(a_high_has_low, (!empty && !run_end), b_status.low_pending)
    `U8U16_ASSERT_NEXT(a_low_follows_high, (pop && !empty && !run_end), (!empty && run_end && (code_unit[15:10] == 6'b110111)))

endmodule

`default_nettype wire

// File: sv/u8u16_front.sv
// ----------------------------------------------------------------------------
// u8u16_front
// Accepts UTF-8 bytes, gathers multi-byte sequences and pushes each
// finished (or cut-short) code point into the point queue.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   byte_accept,
    input  wire logic [7:0]             byte_in,
    input  wire logic                   string_end,
    output logic                        q_push,
    output u8u16_pkg::point_entry_t     q_entry
);

    logic [u8u16_pkg::PointWidth-1:0] pp_reg, pp_next;
    logic [1:0]                       pend_reg, pend_next;

    logic [1:0]                       extra;
    logic [7:0]                       lead_bits;
    logic [u8u16_pkg::PointWidth-1:0] cont_point;
    logic                             emit;
    logic [u8u16_pkg::PointWidth-1:0] emit_point;

    // Lead classification
    always_comb
    begin
        if (byte_in >= u8u16_pkg::Lead4)
            extra = 2'd3;
        else if (byte_in >= u8u16_pkg::Lead3)
            extra = 2'd2;
        else if (byte_in >= u8u16_pkg::Lead2)
            extra = 2'd1;
        else
            extra = 2'd0;
        lead_bits  = byte_in & (u8u16_pkg::ContMask >> extra);
        cont_point = {pp_reg[u8u16_pkg::PointWidth-7:0], (byte_in[5:0] & u8u16_pkg::ContMask[5:0])};
    end

    // Sequence tracking and emit decision
    always_comb
    begin
        pp_next    = pp_reg;
        pend_next  = pend_reg;
        emit       = 1'b0;
        emit_point = '0;
        if (byte_accept)
        begin
            if (pend_reg == 2'd0)
            begin
                if (extra == 2'd0)
                begin
                    emit       = 1'b1;
                    emit_point = {{(u8u16_pkg::PointWidth-8){1'b0}}, byte_in};
                end
                else if (string_end)
                begin
                    emit       = 1'b1;
                    emit_point = {{(u8u16_pkg::PointWidth-8){1'b0}}, lead_bits};
                    pp_next    = '0;
                end
                else
                begin
                    pp_next   = {{(u8u16_pkg::PointWidth-8){1'b0}}, lead_bits};
                    pend_next = extra;
                end
            end
            else
            begin
                if ((pend_reg == 2'd1) || string_end)
                begin
                    emit       = 1'b1;
                    emit_point = cont_point;
                    pp_next    = '0;
                    pend_next  = 2'd0;
                end
                else
                begin
                    pp_next   = cont_point;
                    pend_next = pend_reg - 2'd1;
                end
            end
        end
    end

    assign q_push        = emit;
    assign q_entry.point = emit_point;
    assign q_entry.last  = string_end;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_reg   <= '0;
            pend_reg <= 2'd0;
        end
        else
        begin
            pp_reg   <= pp_next;
            pend_reg <= pend_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/u8u16_queue.sv
// ----------------------------------------------------------------------------
// u8u16_queue
// Short FIFO of decoded code points between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_queue (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    wr_en,
    input  wire u8u16_pkg::point_entry_t wr_entry,
    input  wire logic                    rd_en,
    output u8u16_pkg::point_entry_t      rd_entry,
    output u8u16_pkg::queue_status_t     status
);

    u8u16_pkg::point_entry_t           mem_reg [u8u16_pkg::QDepth];
    logic [u8u16_pkg::QPtrWidth-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [u8u16_pkg::QPtrWidth-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [u8u16_pkg::QCntWidth-1:0]   cnt_reg, cnt_next;
    logic                              do_wr, do_rd;

    assign status.empty = (cnt_reg == '0);
    assign status.full  = (cnt_reg == u8u16_pkg::QCntWidth'(u8u16_pkg::QDepth));
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_entry     = mem_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (!do_wr && do_rd)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule

`default_nettype wire

// File: sv/u8u16_back.sv
// ----------------------------------------------------------------------------
// u8u16_back
// Turns queued code points into UTF-16 code units; holds the low
// surrogate half in a skid slot behind the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_back (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire u8u16_pkg::point_entry_t  q_entry,
    input  wire u8u16_pkg::queue_status_t q_status,
    output logic                          q_pop,
    input  wire logic                     pop,
    output logic                          empty,
    output logic [15:0]                   code_unit,
    output logic                          run_end,
    output logic                          final_unit,
    output u8u16_pkg::back_status_t       status
);

    logic                              out_valid_reg, out_valid_next;
    logic [u8u16_pkg::UnitWidth-1:0]   unit_reg, unit_next;
    logic                              run_end_reg, run_end_next;
    logic                              final_reg, final_next;
    logic                              low_valid_reg, low_valid_next;
    logic [u8u16_pkg::UnitWidth-1:0]   low_unit_reg, low_unit_next;
    logic                              low_final_reg, low_final_next;

    logic                              load;
    logic                              is_supp;
    logic [u8u16_pkg::PointWidth-1:0]  offset;
    logic [u8u16_pkg::UnitWidth-1:0]   high_half, low_half;

    // Surrogate split
    always_comb
    begin
        is_supp   = (q_entry.point >= u8u16_pkg::SuppBase);
        offset    = q_entry.point - u8u16_pkg::SuppBase;
        high_half = u8u16_pkg::HighBase
                  + {{(u8u16_pkg::UnitWidth-11){1'b0}}, offset[20:10]};
        low_half  = u8u16_pkg::LowBase | {{(u8u16_pkg::UnitWidth-10){1'b0}}, offset[9:0]};
    end

    assign load  = !out_valid_reg || pop;
    assign q_pop = load && !low_valid_reg && !q_status.empty;

    // Output register loading
    always_comb
    begin
        out_valid_next = out_valid_reg;
        unit_next      = unit_reg;
        run_end_next   = run_end_reg;
        final_next     = final_reg;
        low_valid_next = low_valid_reg;
        low_unit_next  = low_unit_reg;
        low_final_next = low_final_reg;
        if (load)
        begin
            if (low_valid_reg)
            begin
                out_valid_next = 1'b1;
                unit_next      = low_unit_reg;
                run_end_next   = 1'b1;
                final_next     = low_final_reg;
                low_valid_next = 1'b0;
            end
            else if (!q_status.empty)
            begin
                out_valid_next = 1'b1;
                if (is_supp)
                begin
                    unit_next      = high_half;
                    run_end_next   = 1'b0;
                    final_next     = 1'b0;
                    low_valid_next = 1'b1;
                    low_unit_next  = low_half;
                    low_final_next = q_entry.last;
                end
                else
                begin
                    unit_next    = q_entry.point[u8u16_pkg::UnitWidth-1:0];
                    run_end_next = 1'b1;
                    final_next   = q_entry.last;
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            low_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            low_valid_reg <= low_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        unit_reg      <= unit_next;
        run_end_reg   <= run_end_next;
        final_reg     <= final_next;
        low_unit_reg  <= low_unit_next;
        low_final_reg <= low_final_next;
    end

    assign empty              = !out_valid_reg;
    assign code_unit          = unit_reg;
    assign run_end            = run_end_reg;
    assign final_unit         = final_reg;
    assign status.out_valid   = out_valid_reg;
    assign status.low_pending = low_valid_reg;

endmodule

`default_nettype wire
